### design/abp_pkg.sv
`default_nettype none
package abp_pkg;

   localparam int unsigned CHAN_BITS = 8;
   localparam int unsigned PIX_BITS  = 32;
   localparam int unsigned POS_BITS  = 2;
   localparam int unsigned CSR_BITS  = 3;
   localparam int unsigned SUM_BITS  = 2 * CHAN_BITS;

   localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'd255;

   typedef logic [CHAN_BITS-1:0] chan_type;
   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic [PIX_BITS-1:0]  pix_type;
   typedef logic [SUM_BITS-1:0]  sum_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_SRC_RED   = 3'd0,
      CSR_SRC_GREEN = 3'd1,
      CSR_SRC_BLUE  = 3'd2,
      CSR_SRC_ALPHA = 3'd3,
      CSR_DST_RED   = 3'd4,
      CSR_DST_GREEN = 3'd5,
      CSR_DST_BLUE  = 3'd6,
      CSR_DST_ALPHA = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic mul_en;
      logic div_en;
   } pipe_en_type;

   function automatic chan_type get_chan(pix_type pix, pos_type pos);
      pix_type shifted;
      shifted = pix >> ({3'd0, pos} * 5'd8);
      return shifted[CHAN_BITS-1:0];
   endfunction

   function automatic pix_type put_chan(chan_type c, pos_type pos);
      return {{(PIX_BITS-CHAN_BITS){1'b0}}, c} << ({3'd0, pos} * 5'd8);
   endfunction

   // floor(x/255), exact for x <= 65025 (255*255)
   function automatic chan_type div255(sum_type x);
      logic [SUM_BITS:0] t;
      t = {1'b0, x} + {9'd0, x[SUM_BITS-1:CHAN_BITS]} + 17'd1;
      return t[SUM_BITS-1:CHAN_BITS];
   endfunction

endpackage
`default_nettype wire

### design/abp_mix.sv
`default_nettype none
module abp_mix (
   input  wire                         clock,
   input  wire abp_pkg::pipe_en_type   en,
   input  wire abp_pkg::chan_type      s,
   input  wire abp_pkg::chan_type      d,
   input  wire abp_pkg::chan_type      a,
   output abp_pkg::chan_type           q_ff
);

   abp_pkg::sum_type sum_ff;
   abp_pkg::sum_type sum_in;
   abp_pkg::chan_type q_in;
   abp_pkg::chan_type inv_a;

   always_comb begin
      inv_a  = abp_pkg::CHAN_MAX - a;
      sum_in = ({8'd0, s} * {8'd0, a}) + ({8'd0, inv_a} * {8'd0, d});
      q_in   = abp_pkg::div255(sum_ff);
   end

   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         sum_ff <= sum_in;
      end
      if (en.div_en) begin
         q_ff <= q_in;
      end
   end

endmodule
`default_nettype wire

### design/alpha_blend_pixel_top.sv
`default_nettype none
// alpha_blend_pixel_top: blends a source pixel over a destination pixel.
// Input channel: req_valid/req_stall carry req_src_pixel and req_dst_pixel;
// a transfer happens when req_valid is high and req_stall is low.
// Result channel: rsp_valid/rsp_stall carry rsp_out_pixel, same rule.
// Channel byte positions for both surfaces are set through the csr_ port
// (csr_wr_en, csr_index, csr_wdata); write them only while the block is idle.
// Red, green and blue become floor((s*a + (255-a)*d)/255), alpha is the
// destination alpha, and the result is packed in destination order.
// Pipeline: channel select, multiply and add, divide by 255, repack, each
// registered before rsp_valid. Throughput: one pixel per cycle while the
// receiver does not stall, set by the four stages with one register each.
// Stall: each stage moves when it is empty or the stage after it moves, so
// bubbles close up; req_stall rises only when every stage holds an item and
// the receiver stalls. Nothing is dropped or repeated.
// Reset: synchronous, active high; empties the pipeline and restores the
// default RGBA byte order (red 0, green 1, blue 2, alpha 3) on both surfaces.
module alpha_blend_pixel_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_src_pixel,
   input  wire  [31:0] req_dst_pixel,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_out_pixel,
   input  wire         csr_wr_en,
   input  wire  [2:0]  csr_index,
   input  wire  [1:0]  csr_wdata
);

   abp_pkg::pos_type src_red_pos_ff, src_green_pos_ff, src_blue_pos_ff, src_alpha_pos_ff;
   abp_pkg::pos_type dst_red_pos_ff, dst_green_pos_ff, dst_blue_pos_ff, dst_alpha_pos_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   abp_pkg::chan_type s_r_ff, s_g_ff, s_b_ff, a_ff;
   abp_pkg::chan_type d_r_ff, d_g_ff, d_b_ff, d_a1_ff, d_a2_ff, d_a3_ff;
   abp_pkg::chan_type q_r, q_g, q_b;
   abp_pkg::pix_type  out_in;
   abp_pkg::pix_type  out_ff;
   abp_pkg::pipe_en_type mix_en;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         src_red_pos_ff   <= 2'd0;
         src_green_pos_ff <= 2'd1;
         src_blue_pos_ff  <= 2'd2;
         src_alpha_pos_ff <= 2'd3;
         dst_red_pos_ff   <= 2'd0;
         dst_green_pos_ff <= 2'd1;
         dst_blue_pos_ff  <= 2'd2;
         dst_alpha_pos_ff <= 2'd3;
      end else if (csr_wr_en) begin
         unique case (abp_pkg::csr_index_type'(csr_index))
            abp_pkg::CSR_SRC_RED:   src_red_pos_ff   <= csr_wdata;
            abp_pkg::CSR_SRC_GREEN: src_green_pos_ff <= csr_wdata;
            abp_pkg::CSR_SRC_BLUE:  src_blue_pos_ff  <= csr_wdata;
            abp_pkg::CSR_SRC_ALPHA: src_alpha_pos_ff <= csr_wdata;
            abp_pkg::CSR_DST_RED:   dst_red_pos_ff   <= csr_wdata;
            abp_pkg::CSR_DST_GREEN: dst_green_pos_ff <= csr_wdata;
            abp_pkg::CSR_DST_BLUE:  dst_blue_pos_ff  <= csr_wdata;
            abp_pkg::CSR_DST_ALPHA: dst_alpha_pos_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage enables
   always_comb begin
      en4       = !v4_ff || !rsp_stall;
      en3       = !v3_ff || en4;
      en2       = !v2_ff || en3;
      en1       = !v1_ff || en2;
      req_stall = !en1;
      mix_en.mul_en = en2;
      mix_en.div_en = en3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 1: channel select
   always_ff @(posedge clock) begin
      if (en1) begin
         s_r_ff  <= abp_pkg::get_chan(req_src_pixel, src_red_pos_ff);
         s_g_ff  <= abp_pkg::get_chan(req_src_pixel, src_green_pos_ff);
         s_b_ff  <= abp_pkg::get_chan(req_src_pixel, src_blue_pos_ff);
         a_ff    <= abp_pkg::get_chan(req_src_pixel, src_alpha_pos_ff);
         d_r_ff  <= abp_pkg::get_chan(req_dst_pixel, dst_red_pos_ff);
         d_g_ff  <= abp_pkg::get_chan(req_dst_pixel, dst_green_pos_ff);
         d_b_ff  <= abp_pkg::get_chan(req_dst_pixel, dst_blue_pos_ff);
         d_a1_ff <= abp_pkg::get_chan(req_dst_pixel, dst_alpha_pos_ff);
      end
      if (en2) d_a2_ff <= d_a1_ff;
      if (en3) d_a3_ff <= d_a2_ff;
      if (en4) out_ff  <= out_in;
   end

   // stages 2 and 3: multiply-add, divide by 255
   abp_mix u_mix_r (.clock(clock), .en(mix_en), .s(s_r_ff), .d(d_r_ff), .a(a_ff), .q_ff(q_r));
   abp_mix u_mix_g (.clock(clock), .en(mix_en), .s(s_g_ff), .d(d_g_ff), .a(a_ff), .q_ff(q_g));
   abp_mix u_mix_b (.clock(clock), .en(mix_en), .s(s_b_ff), .d(d_b_ff), .a(a_ff), .q_ff(q_b));

   // stage 4: repack, shared bytes add with carry
   always_comb begin
      out_in = abp_pkg::put_chan(q_r, dst_red_pos_ff)
             + abp_pkg::put_chan(q_g, dst_green_pos_ff)
             + abp_pkg::put_chan(q_b, dst_blue_pos_ff)
             + abp_pkg::put_chan(d_a3_ff, dst_alpha_pos_ff);
   end

   assign rsp_valid     = v4_ff;
   assign rsp_out_pixel = out_ff;

endmodule
`default_nettype wire
